// ===== sv/cdd_pkg.sv =====
package cdd_pkg;

	localparam int DAY_W   = 5;
	localparam int MONTH_W = 4;
	localparam int YEAR_W  = 14;
	localparam int COUNT_W = 22;
	localparam int STAT_W  = 2;

	// years above this are clamped before use
	localparam int MAX_YEAR = 9999;

	// ordinal day number, wide enough for any 14-bit year
	localparam int ORD_W = 23;
	// days before the first of a month, at most 334
	localparam int MB_W  = 9;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	localparam logic [STAT_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_EMPTY     = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_BAD_MONTH = 2'd2;

	typedef struct packed {
		logic [DAY_W-1:0]   first_day;
		logic [MONTH_W-1:0] first_month;
		logic [YEAR_W-1:0]  first_year;
		logic [DAY_W-1:0]   second_day;
		logic [MONTH_W-1:0] second_month;
		logic [YEAR_W-1:0]  second_year;
	} in_item_t;

	typedef struct packed {
		logic [COUNT_W-1:0] day_count;
		logic [STAT_W-1:0]  status;
	} out_item_t;

	// one date after classification: clamped year, month offset in its year
	typedef struct packed {
		logic [DAY_W-1:0]  day;
		logic [MB_W-1:0]   month_base;
		logic              past_feb;
		logic [YEAR_W-1:0] year;
	} date_t;

	// queue entry between front and back
	typedef struct packed {
		logic [STAT_W-1:0] status;
		date_t [1:0]       dates;
	} job_t;

endpackage

// ===== sv/cdd_front.sv =====
module cdd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  cdd_pkg::in_item_t in_data,
	output logic              push_valid,
	input  logic              push_ready,
	output cdd_pkg::job_t     push_data
);

	logic          valid_q;
	cdd_pkg::job_t job_q;
	cdd_pkg::job_t job_d;

	function automatic logic [cdd_pkg::MB_W-1:0] month_base(
		input logic [cdd_pkg::MONTH_W-1:0] m
	);
		logic [cdd_pkg::MB_W-1:0] r;
		unique case (m)
			4'd1:    r = 9'd0;
			4'd2:    r = 9'd31;
			4'd3:    r = 9'd59;
			4'd4:    r = 9'd90;
			4'd5:    r = 9'd120;
			4'd6:    r = 9'd151;
			4'd7:    r = 9'd181;
			4'd8:    r = 9'd212;
			4'd9:    r = 9'd243;
			4'd10:   r = 9'd273;
			4'd11:   r = 9'd304;
			4'd12:   r = 9'd334;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	function automatic logic bad_month(input logic [cdd_pkg::MONTH_W-1:0] m);
		return (m == 4'd0) || (m > 4'd12);
	endfunction

	function automatic cdd_pkg::date_t classify(
		input logic [cdd_pkg::DAY_W-1:0]   d,
		input logic [cdd_pkg::MONTH_W-1:0] m,
		input logic [cdd_pkg::YEAR_W-1:0]  y
	);
		cdd_pkg::date_t r;
		r.day        = d;
		r.month_base = month_base(m);
		r.past_feb   = (m > 4'd2);
		if (int'(y) > cdd_pkg::MAX_YEAR) begin
			r.year = cdd_pkg::YEAR_W'(cdd_pkg::MAX_YEAR);
		end else begin
			r.year = y;
		end
		return r;
	endfunction

	always_comb begin
		job_d.dates[0] = classify(in_data.first_day, in_data.first_month, in_data.first_year);
		job_d.dates[1] = classify(in_data.second_day, in_data.second_month,
			in_data.second_year);
		// empty date wins over a bad month
		if (in_data.first_day == '0 || in_data.second_day == '0) begin
			job_d.status = cdd_pkg::STATUS_EMPTY;
		end else if (bad_month(in_data.first_month) || bad_month(in_data.second_month)) begin
			job_d.status = cdd_pkg::STATUS_BAD_MONTH;
		end else begin
			job_d.status = cdd_pkg::STATUS_OK;
		end
	end

	assign in_ready   = !valid_q || push_ready;
	assign push_valid = valid_q;
	assign push_data  = job_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			job_q <= job_d;
		end
	end

endmodule

// ===== sv/cdd_queue.sv =====
module cdd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  cdd_pkg::job_t push_data,
	output logic          pop_valid,
	input  logic          pop_ready,
	output cdd_pkg::job_t pop_data
);

	localparam int DEPTH = 2;

	cdd_pkg::job_t mem_q [DEPTH];
	logic          wptr_q;
	logic          rptr_q;
	logic [1:0]    count_q;
	logic          push;
	logic          pop;

	assign push_ready = (count_q != 2'(DEPTH));
	assign pop_valid  = (count_q != 2'd0);
	assign pop_data   = mem_q[rptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_data;
		end
	end

endmodule

// ===== sv/cdd_back.sv =====
module cdd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pop_valid,
	output logic               pop_ready,
	input  cdd_pkg::job_t      pop_data,
	output logic               out_valid,
	input  logic               out_ready,
	output cdd_pkg::out_item_t out_data
);

	// floor(x / 100) = (x * 5243) >> 19 for x below 43690
	localparam int RECIP_100 = 5243;
	localparam int RECIP_SH  = 19;
	localparam int PROD_W    = cdd_pkg::YEAR_W + 13;
	localparam int Q_W       = PROD_W - RECIP_SH;
	localparam int LC_W      = cdd_pkg::YEAR_W - 1;

	// stage 1: year times reciprocal of 100
	logic                     v_s1;
	cdd_pkg::job_t            job_s1;
	logic [PROD_W-1:0]        prod_s1 [2];

	// stage 2: 365 y and leap years before y
	logic                     v_s2;
	cdd_pkg::job_t            job_s2;
	logic [cdd_pkg::ORD_W-1:0] y365_s2 [2];
	logic [LC_W-1:0]          lc_s2 [2];
	logic                     leap_s2 [2];

	// stage 3: ordinals
	logic                     v_s3;
	logic [cdd_pkg::STAT_W-1:0] stat_s3;
	logic [cdd_pkg::ORD_W-1:0] ord_s3 [2];

	// output register
	logic                     out_v_q;
	cdd_pkg::out_item_t       out_q;

	logic adv_out, adv3, adv2, adv1;

	assign adv_out   = !out_v_q || out_ready;
	assign adv3      = !v_s3 || adv_out;
	assign adv2      = !v_s2 || adv3;
	assign adv1      = !v_s1 || adv2;
	assign pop_ready = adv1;
	assign out_valid = out_v_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (adv1) begin
				v_s1 <= pop_valid;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
			if (adv3) begin
				v_s3 <= v_s2;
			end
			if (adv_out) begin
				out_v_q <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && pop_valid) begin
			job_s1 <= pop_data;
			for (int i = 0; i < 2; i++) begin
				prod_s1[i] <= PROD_W'(pop_data.dates[i].year) * PROD_W'(RECIP_100);
			end
		end
	end

	always_ff @(posedge clk) begin
		logic [Q_W-1:0]    q;
		logic              r_nz;
		logic [LC_W-1:0]   c4;
		logic [LC_W-1:0]   c100;
		logic [LC_W-1:0]   c400;
		logic [cdd_pkg::YEAR_W-1:0] y;
		if (adv2 && v_s1) begin
			job_s2 <= job_s1;
			for (int i = 0; i < 2; i++) begin
				y    = job_s1.dates[i].year;
				q    = prod_s1[i][PROD_W-1:RECIP_SH];
				r_nz = ((cdd_pkg::YEAR_W+1)'(y) !=
					(cdd_pkg::YEAR_W+1)'(q) * (cdd_pkg::YEAR_W+1)'(100));
				// ceilings of y/4, y/100, y/400 count leap days of years 0..y-1
				c4   = LC_W'(y[cdd_pkg::YEAR_W-1:2]) + LC_W'(y[1:0] != 2'd0);
				c100 = LC_W'(q) + LC_W'(r_nz);
				c400 = LC_W'(q[Q_W-1:2]) + LC_W'(r_nz || q[1:0] != 2'd0);
				lc_s2[i]   <= c4 - c100 + c400;
				y365_s2[i] <= cdd_pkg::ORD_W'(y) * cdd_pkg::ORD_W'(365);
				leap_s2[i] <= (y[1:0] == 2'd0) && (r_nz || q[1:0] == 2'd0);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv3 && v_s2) begin
			stat_s3 <= job_s2.status;
			for (int i = 0; i < 2; i++) begin
				ord_s3[i] <= y365_s2[i]
					+ cdd_pkg::ORD_W'(lc_s2[i])
					+ cdd_pkg::ORD_W'(job_s2.dates[i].month_base)
					+ cdd_pkg::ORD_W'(job_s2.dates[i].past_feb && leap_s2[i])
					+ cdd_pkg::ORD_W'(job_s2.dates[i].day);
			end
		end
	end

	always_ff @(posedge clk) begin
		logic [cdd_pkg::ORD_W-1:0] diff;
		if (adv_out && v_s3) begin
			diff = (ord_s3[0] > ord_s3[1]) ? (ord_s3[0] - ord_s3[1]) : (ord_s3[1] - ord_s3[0]);
			out_q.status <= stat_s3;
			if (stat_s3 != cdd_pkg::STATUS_OK) begin
				out_q.day_count <= '0;
			end else if (diff > cdd_pkg::ORD_W'(cdd_pkg::COUNT_MAX)) begin
				out_q.day_count <= cdd_pkg::COUNT_MAX;
			end else begin
				out_q.day_count <= diff[cdd_pkg::COUNT_W-1:0];
			end
		end
	end

endmodule

// ===== sv/calendar_day_difference_top.sv =====
// gregorian day difference: each item carries two dates (day, month, year) and
// yields one result with the absolute number of days between them under the
// proleptic gregorian leap rules; the order of the two dates does not matter.
// a zero day gives status empty, otherwise a month outside 1..12 gives status
// bad month, both with a count of zero; days past a month's end roll over into
// the next month, years above 9999 are clamped to 9999, and the count saturates
// at the largest 22-bit value. one item is taken every clock cycle as long as
// the output side keeps taking results; an item passes through the front
// register, the two-entry queue, three arithmetic stages and the output
// register, with the per-year multiply by the reciprocal of 100 setting the
// stage split.
module calendar_day_difference_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  cdd_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output cdd_pkg::out_item_t out_data
);

	// front to queue
	logic          push_valid;
	logic          push_ready;
	cdd_pkg::job_t push_data;

	// queue to back
	logic          pop_valid;
	logic          pop_ready;
	cdd_pkg::job_t pop_data;

	// front: takes an item, sets its status, clamps years, looks up month offsets
	cdd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	// short queue so front and back stall independently
	cdd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// back: ordinal of each date, difference, saturation, output register
	cdd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ===== tb/calendar_day_difference_top_tb.sv =====
module calendar_day_difference_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// run length and pressure points
	localparam int RANDOM_ITEMS = 1880;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int HOLD_CYCLES  = 200;
	localparam int DRAIN_CYCLES = 30;
	// random item indexes where the pressure phases start and end
	localparam int BURST_START  = 600;
	localparam int BURST_END    = 700;
	localparam int STEADY_START = 1000;
	localparam int STEADY_END   = 1250;
	localparam int PAUSE_AT     = 1400;

	localparam int unsigned YEAR_TOP = (1 << cdd_pkg::YEAR_W) - 1;

	// days in a common year before the first of each month
	localparam int unsigned DAYS_BEFORE_MONTH [12] =
		'{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

	// years where the leap rules change, for the near-boundary draws
	localparam int unsigned RULE_YEARS [8] =
		'{0, 100, 400, 1600, 1900, 2000, 2100, 9999};

	// one row of the directed table: the item and, where it is obvious,
	// the result written out by hand
	typedef struct packed {
		cdd_pkg::in_item_t  stim;
		bit                 typed;
		cdd_pkg::out_item_t result;
	} table_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	cdd_pkg::in_item_t  in_data = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	cdd_pkg::out_item_t out_data;

	cdd_pkg::out_item_t pending_results [$];
	table_row_t         directed [$];

	int cycle_count = 0;
	int fail_count = 0;
	int items_sent = 0;
	int results_seen = 0;
	int ok_seen = 0;
	int empty_seen = 0;
	int bad_month_seen = 0;
	int unsigned widest_count = 0;

	// handshake between the sender and the receiver for the pressure phases
	int hold_asks = 0;
	int holds_done = 0;
	bit steady = 1'b0;

	calendar_day_difference_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// watchdog: a hung handshake ends the run here
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d results still pending",
			cycle_count, pending_results.size());
		$display("TEST FAILED");
		$finish;
	end

	// ---------------------------------------------------------------
	// predictor
	// ---------------------------------------------------------------

	function automatic bit leap_year(input int unsigned year);
		if (year % 400 == 0)
			return 1'b1;
		if (year % 100 == 0)
			return 1'b0;
		return (year % 4) == 0;
	endfunction

	// day number counted from the first day of year zero; month is 1..12
	function automatic int unsigned day_number(input logic [cdd_pkg::DAY_W-1:0] day,
			input logic [cdd_pkg::MONTH_W-1:0] month,
			input logic [cdd_pkg::YEAR_W-1:0] year);
		int unsigned y;
		int unsigned n;
		y = (year > cdd_pkg::MAX_YEAR) ? cdd_pkg::MAX_YEAR : year;
		// whole years before this one, with their leap days
		n = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
		n += DAYS_BEFORE_MONTH[month - 1];
		if (month > 2 && leap_year(y))
			n += 1;
		// days past the end of a month simply roll forward
		return n + day;
	endfunction

	function automatic bit month_ok(input logic [cdd_pkg::MONTH_W-1:0] month);
		return month >= 1 && month <= 12;
	endfunction

	function automatic cdd_pkg::out_item_t predict_gap(input cdd_pkg::in_item_t it);
		cdd_pkg::out_item_t r;
		int unsigned a;
		int unsigned b;
		int unsigned diff;
		r = '0;
		// an empty date wins over a bad month
		if (it.first_day == 0 || it.second_day == 0) begin
			r.status = cdd_pkg::STATUS_EMPTY;
			return r;
		end
		if (!month_ok(it.first_month) || !month_ok(it.second_month)) begin
			r.status = cdd_pkg::STATUS_BAD_MONTH;
			return r;
		end
		a = day_number(it.first_day, it.first_month, it.first_year);
		b = day_number(it.second_day, it.second_month, it.second_year);
		diff = (a > b) ? a - b : b - a;
		if (diff > cdd_pkg::COUNT_MAX)
			diff = cdd_pkg::COUNT_MAX;
		r.day_count = diff[cdd_pkg::COUNT_W-1:0];
		r.status = cdd_pkg::STATUS_OK;
		return r;
	endfunction

	// ---------------------------------------------------------------
	// stimulus helpers
	// ---------------------------------------------------------------

	function automatic table_row_t make_row(input int d1, input int m1, input int y1,
			input int d2, input int m2, input int y2, input bit typed,
			input int count, input logic [cdd_pkg::STAT_W-1:0] stat);
		table_row_t row;
		row.stim.first_day    = d1[cdd_pkg::DAY_W-1:0];
		row.stim.first_month  = m1[cdd_pkg::MONTH_W-1:0];
		row.stim.first_year   = y1[cdd_pkg::YEAR_W-1:0];
		row.stim.second_day   = d2[cdd_pkg::DAY_W-1:0];
		row.stim.second_month = m2[cdd_pkg::MONTH_W-1:0];
		row.stim.second_year  = y2[cdd_pkg::YEAR_W-1:0];
		row.typed             = typed;
		row.result.day_count  = count[cdd_pkg::COUNT_W-1:0];
		row.result.status     = stat;
		return row;
	endfunction

	// mostly back to back, sometimes a few cycles, rarely a long gap
	function automatic int idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [cdd_pkg::YEAR_W-1:0] pick_year();
		int unsigned r;
		int y;
		r = $urandom_range(0, 9);
		if (r < 4) begin
			// whole field, clamped years above 9999 included
			y = $urandom_range(0, YEAR_TOP);
		end else if (r < 8) begin
			y = RULE_YEARS[$urandom_range(0, 7)] + $urandom_range(0, 8) - 4;
		end else begin
			// around the clamp point
			y = $urandom_range(cdd_pkg::MAX_YEAR - 10, cdd_pkg::MAX_YEAR + 10);
		end
		if (y < 0)
			y = 0;
		if (y > YEAR_TOP)
			y = YEAR_TOP;
		return y[cdd_pkg::YEAR_W-1:0];
	endfunction

	function automatic cdd_pkg::in_item_t random_pair();
		cdd_pkg::in_item_t it;
		int y2;
		int unsigned r;
		it.first_day    = cdd_pkg::DAY_W'($urandom_range(1, 31));
		it.first_month  = cdd_pkg::MONTH_W'($urandom_range(1, 12));
		it.first_year   = pick_year();
		it.second_day   = cdd_pkg::DAY_W'($urandom_range(1, 31));
		it.second_month = cdd_pkg::MONTH_W'($urandom_range(1, 12));
		if ($urandom_range(0, 9) < 4) begin
			// nearby years keep the leap day handling in view
			y2 = int'(it.first_year) + $urandom_range(0, 6) - 3;
			if (y2 < 0)
				y2 = 0;
			if (y2 > YEAR_TOP)
				y2 = YEAR_TOP;
			it.second_year = y2[cdd_pkg::YEAR_W-1:0];
		end else begin
			it.second_year = pick_year();
		end
		// about one item in ten is broken: an empty date or a bad month
		r = $urandom_range(0, 99);
		if (r < 3) begin
			it.first_day = '0;
		end else if (r < 6) begin
			it.second_day = '0;
		end else if (r < 8) begin
			it.first_month = cdd_pkg::MONTH_W'(($urandom_range(0, 1) != 0) ?
				$urandom_range(13, 15) : 0);
		end else if (r < 10) begin
			it.second_month = cdd_pkg::MONTH_W'(($urandom_range(0, 1) != 0) ?
				$urandom_range(13, 15) : 0);
		end
		return it;
	endfunction

	// offer one item after an optional gap and log its result once taken
	task automatic offer(input cdd_pkg::in_item_t it, input cdd_pkg::out_item_t want,
			input int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (!in_ready);
		pending_results.push_back(want);
		items_sent++;
	endtask

	function automatic void note_failure(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("mismatch: %s", msg);
	endfunction

	// ---------------------------------------------------------------
	// result checker
	// ---------------------------------------------------------------

	always @(posedge clk) begin
		cdd_pkg::out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				note_failure($sformatf("result count %0d status %0d with no item pending",
					out_data.day_count, out_data.status));
			end else begin
				want = pending_results.pop_front();
				if (out_data.day_count !== want.day_count)
					note_failure($sformatf("result %0d day_count expected %0d got %0d",
						results_seen, want.day_count, out_data.day_count));
				if (out_data.status !== want.status)
					note_failure($sformatf("result %0d status expected %0d got %0d",
						results_seen, want.status, out_data.status));
			end
			case (out_data.status)
				cdd_pkg::STATUS_OK:        ok_seen++;
				cdd_pkg::STATUS_EMPTY:     empty_seen++;
				cdd_pkg::STATUS_BAD_MONTH: bad_month_seen++;
				default: ;
			endcase
			if (out_data.day_count > widest_count)
				widest_count = out_data.day_count;
		end
	end

	// ---------------------------------------------------------------
	// receiver: random stalls, one long hold on request, steady stretch
	// ---------------------------------------------------------------

	initial begin
		int stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_asks != holds_done) begin
				// long hold so the pipe fills and pushes back on the input
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				holds_done++;
			end else if (steady) begin
				out_ready <= 1'b1;
				@(posedge clk);
			end else begin
				stall = idle_len();
				if (stall > 0) begin
					out_ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	end

	// ---------------------------------------------------------------
	// sender and run control
	// ---------------------------------------------------------------

	initial begin
		cdd_pkg::in_item_t it;
		cdd_pkg::out_item_t want;
		int gap;

		// leap rules, empty and bad month cases, clamping and field extremes
		directed = '{
			make_row(0, 1, 2000, 1, 1, 2000, 1'b1, 0, cdd_pkg::STATUS_EMPTY),
			make_row(1, 1, 2000, 0, 1, 2000, 1'b1, 0, cdd_pkg::STATUS_EMPTY),
			make_row(0, 0, 0, 0, 15, 16383, 1'b1, 0, cdd_pkg::STATUS_EMPTY),
			make_row(1, 0, 2000, 1, 1, 2000, 1'b1, 0, cdd_pkg::STATUS_BAD_MONTH),
			make_row(31, 13, 2000, 1, 1, 2000, 1'b1, 0, cdd_pkg::STATUS_BAD_MONTH),
			make_row(1, 1, 2000, 1, 15, 2000, 1'b1, 0, cdd_pkg::STATUS_BAD_MONTH),
			make_row(31, 15, 16383, 31, 15, 16383, 1'b1, 0, cdd_pkg::STATUS_BAD_MONTH),
			make_row(15, 6, 1999, 15, 6, 1999, 1'b1, 0, cdd_pkg::STATUS_OK),
			make_row(1, 1, 0, 1, 1, 0, 1'b1, 0, cdd_pkg::STATUS_OK),
			make_row(1, 1, 0, 31, 12, 9999, 1'b0, 0, cdd_pkg::STATUS_OK),
			make_row(31, 12, 16383, 1, 1, 0, 1'b0, 0, cdd_pkg::STATUS_OK),
			make_row(31, 12, 16383, 31, 12, 9999, 1'b1, 0, cdd_pkg::STATUS_OK),
			// february 31 rolls into march
			make_row(31, 2, 2001, 3, 3, 2001, 1'b1, 0, cdd_pkg::STATUS_OK),
			make_row(31, 2, 2000, 2, 3, 2000, 1'b1, 0, cdd_pkg::STATUS_OK),
			// century years: only every fourth one is leap
			make_row(28, 2, 1900, 1, 3, 1900, 1'b1, 1, cdd_pkg::STATUS_OK),
			make_row(28, 2, 2000, 1, 3, 2000, 1'b1, 2, cdd_pkg::STATUS_OK),
			make_row(28, 2, 2100, 1, 3, 2100, 1'b1, 1, cdd_pkg::STATUS_OK),
			make_row(28, 2, 2004, 1, 3, 2004, 1'b1, 2, cdd_pkg::STATUS_OK),
			make_row(1, 3, 0, 28, 2, 0, 1'b1, 2, cdd_pkg::STATUS_OK),
			make_row(1, 1, 2024, 1, 1, 2023, 1'b1, 365, cdd_pkg::STATUS_OK),
			make_row(1, 1, 2025, 1, 1, 2024, 1'b1, 366, cdd_pkg::STATUS_OK),
			make_row(31, 12, 1999, 1, 1, 2000, 1'b1, 1, cdd_pkg::STATUS_OK),
			make_row(31, 12, 1600, 1, 1, 400, 1'b0, 0, cdd_pkg::STATUS_OK)
		};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			want = directed[i].typed ? directed[i].result : predict_gap(directed[i].stim);
			offer(directed[i].stim, want, idle_len());
		end

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == BURST_START)
				hold_asks++;
			if (n == STEADY_START)
				steady = 1'b1;
			if (n == STEADY_END)
				steady = 1'b0;
			if (n == PAUSE_AT) begin
				// let everything in flight come out before going on
				in_valid <= 1'b0;
				do @(posedge clk); while (pending_results.size() != 0);
			end
			// no gaps while the receiver holds or runs steady
			if ((n >= BURST_START && n < BURST_END) ||
					(n >= STEADY_START && n < STEADY_END))
				gap = 0;
			else
				gap = idle_len();
			it = random_pair();
			offer(it, predict_gap(it), gap);
		end
		in_valid <= 1'b0;

		// drain, then give stray results time to show up
		do @(posedge clk); while (pending_results.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_results.size() != 0)
			note_failure($sformatf("%0d results never arrived", pending_results.size()));

		$display("covered %0d items (%0d directed): %0d ok, %0d empty, %0d bad month",
			items_sent, directed.size(), ok_seen, empty_seen, bad_month_seen);
		$display("largest day count %0d, one %0d-cycle output hold, %0d failures",
			widest_count, HOLD_CYCLES, fail_count);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
